/* hdl/eptab_pkg.sv */
// shared constants and types for the expiring packet table
package eptab_pkg;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned KeyBits    = 48;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned IdxBits    = $clog2(TableDepth);
  localparam int unsigned CntBits    = $clog2(TableDepth + 1);
  localparam int unsigned EntryBits  = KeyBits + TimeBits;

  localparam logic [1:0] StInserted  = 2'd0;
  localparam logic [1:0] StDuplicate = 2'd1;
  localparam logic [1:0] StFound     = 2'd2;
  localparam logic [1:0] StNotFound  = 2'd3;

  localparam logic ReqEnqueue = 1'b0;
  localparam logic ReqLookup  = 1'b1;

  typedef struct packed {
    logic [KeyBits-1:0]  key;
    logic [TimeBits-1:0] expiry;
  } entry_t;

endpackage

/* hdl/eptab_ram.sv */
// generic single-port-write, single-read ram with registered read data
module eptab_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/expiring_packet_table_evict_oldest.sv */
// expiring packet table: one scan of the entry memory per request
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid_i/req_stall_o | req_type, packet_id, lifetime, now_time
//   rsp     | out       | rsp_valid_o/rsp_stall_i | status .. drop_count
//   cfg     | in        | cfg_we_i              | max_entries
//
// a request runs through the scan (one read per slot, data back in the next
// cycle), a resolve step, a write-back step, a step with the result held and
// an idle step.
// valid bits sit in flip-flops and clear at reset, so no clearing pass.
// a result waits in the output register while stalled, and the next request
// is taken once the previous result has been transferred.
module expiring_packet_table_evict_oldest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic        req_type_i,
  input  logic [47:0] packet_id_i,
  input  logic [31:0] lifetime_i,
  input  logic [31:0] now_time_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output logic [1:0]  status_o,
  output logic        evicted_o,
  output logic [47:0] evicted_id_o,
  output logic [31:0] remaining_life_o,
  output logic [7:0]  occupancy_o,
  output logic [31:0] drop_count_o
);

  localparam int unsigned IB = eptab_pkg::IdxBits;
  localparam int unsigned CB = eptab_pkg::CntBits;
  localparam int unsigned KB = eptab_pkg::KeyBits;
  localparam int unsigned TB = eptab_pkg::TimeBits;

  typedef enum logic [2:0] {SIdle, SScan, SResolve, SWrite, SOut} state_e;

  state_e state_q;
  logic [7:0]  max_q;
  logic [eptab_pkg::TableDepth-1:0] valid_q;
  logic [31:0] drops_q;
  logic        type_q;
  logic [KB-1:0] key_q;
  logic [TB-1:0] life_q, now_q;
  logic [IB:0] raddr_q;        // read address, equal to depth at the end
  logic        rd_vld_q;       // read data in flight
  logic [IB-1:0] rd_idx_q;
  logic        hit_q;
  logic [TB-1:0] hit_exp_q;
  logic        best_vld_q;
  logic [IB-1:0] best_idx_q;
  logic [KB-1:0] best_key_q;
  logic [TB-1:0] best_exp_q;
  logic        free_vld_q;
  logic [IB-1:0] free_idx_q;
  logic [CB-1:0] cnt_q;
  logic        wr_q;
  logic [IB-1:0] wr_idx_q;
  logic [TB-1:0] exp_q;
  logic [1:0]  status_q;
  logic        rsp_evicted_q;
  logic [47:0] evicted_id_q;
  logic [31:0] remaining_q;
  logic [7:0]  occ_q;

  eptab_pkg::entry_t rd_entry, wr_entry;
  logic ram_we;

  assign wr_entry = '{key: key_q, expiry: exp_q};
  assign ram_we   = (state_q == SWrite) && wr_q;

  eptab_ram #(.Width(eptab_pkg::EntryBits), .Depth(eptab_pkg::TableDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (wr_entry),
    .raddr_i (raddr_q[IB-1:0]),
    .rdata_o (rd_entry)
  );

  // scan evaluation of the entry just read
  logic cur_live, cur_better;
  assign cur_live = rd_vld_q && valid_q[rd_idx_q] && (rd_entry.expiry > now_q);
  assign cur_better = !best_vld_q || (rd_entry.expiry < best_exp_q) ||
                      ((rd_entry.expiry == best_exp_q) && (rd_entry.key < best_key_q));

  // effective limit clamped to 1..depth
  logic [CB-1:0] limit;
  always_comb begin
    if (max_q == 8'd0) limit = CB'(1);
    else if (32'(max_q) > eptab_pkg::TableDepth) limit = CB'(eptab_pkg::TableDepth);
    else limit = CB'(max_q);
  end

  // saturating expiry
  logic [TB:0] exp_sum;
  assign exp_sum = {1'b0, now_q} + {1'b0, life_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      max_q       <= 8'd128;
      valid_q     <= '0;
      drops_q     <= '0;
      rd_vld_q    <= 1'b0;
      rsp_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      unique case (state_q)
        SIdle: begin
          if (req_valid_i) begin
            type_q     <= req_type_i;
            key_q      <= packet_id_i[KB-1:0];
            life_q     <= lifetime_i[TB-1:0];
            now_q      <= now_time_i[TB-1:0];
            raddr_q    <= '0;
            rd_vld_q   <= 1'b0;
            hit_q      <= 1'b0;
            best_vld_q <= 1'b0;
            free_vld_q <= 1'b0;
            cnt_q      <= '0;
            state_q    <= SScan;
          end
        end
        SScan: begin
          // issue next read
          if (raddr_q <= (IB+1)'(eptab_pkg::TableDepth - 1)) begin
            rd_vld_q <= 1'b1;
            rd_idx_q <= raddr_q[IB-1:0];
            raddr_q  <= raddr_q + 1'b1;
          end else begin
            rd_vld_q <= 1'b0;
          end
          // evaluate returned entry; purge expired
          if (rd_vld_q) begin
            if (!cur_live) begin
              valid_q[rd_idx_q] <= 1'b0;
              if (!free_vld_q) begin
                free_vld_q <= 1'b1;
                free_idx_q <= rd_idx_q;
              end
            end else begin
              cnt_q <= cnt_q + 1'b1;
              if (!hit_q && rd_entry.key == key_q) begin
                hit_q     <= 1'b1;
                hit_exp_q <= rd_entry.expiry;
              end
              if (cur_better) begin
                best_vld_q <= 1'b1;
                best_idx_q <= rd_idx_q;
                best_key_q <= rd_entry.key;
                best_exp_q <= rd_entry.expiry;
              end
            end
          end
          if (!rd_vld_q && raddr_q > (IB+1)'(eptab_pkg::TableDepth - 1)) state_q <= SResolve;
        end
        SResolve: begin
          rsp_evicted_q <= 1'b0;
          evicted_id_q  <= '0;
          remaining_q   <= '0;
          wr_q          <= 1'b0;
          occ_q         <= 8'(cnt_q);
          exp_q <= exp_sum[TB] ? {TB{1'b1}} : exp_sum[TB-1:0];
          if (type_q == eptab_pkg::ReqLookup) begin
            if (hit_q) begin
              status_q    <= eptab_pkg::StFound;
              remaining_q <= 32'(hit_exp_q - now_q);
            end else begin
              status_q <= eptab_pkg::StNotFound;
            end
          end else if (hit_q) begin
            status_q <= eptab_pkg::StDuplicate;
          end else begin
            status_q <= eptab_pkg::StInserted;
            wr_q     <= 1'b1;
            if (cnt_q >= limit && best_vld_q) begin
              rsp_evicted_q <= 1'b1;
              evicted_id_q  <= 48'(best_key_q);
              valid_q[best_idx_q] <= 1'b0;
              if (drops_q != '1) drops_q <= drops_q + 1'b1;
              // lowest free slot, counting the victim
              wr_idx_q <= (free_vld_q && free_idx_q < best_idx_q) ? free_idx_q : best_idx_q;
            end else begin
              wr_idx_q <= free_idx_q;
              occ_q    <= 8'(cnt_q + 1'b1);
              if (!free_vld_q) wr_q <= 1'b0;
            end
          end
          state_q <= SWrite;
        end
        SWrite: begin
          if (wr_q) valid_q[wr_idx_q] <= 1'b1;
          rsp_valid_o      <= 1'b1;
          status_o         <= status_q;
          evicted_o        <= rsp_evicted_q;
          evicted_id_o     <= evicted_id_q;
          remaining_life_o <= remaining_q;
          occupancy_o      <= occ_q;
          drop_count_o     <= drops_q;
          state_q          <= SOut;
        end
        SOut: begin
          if (!rsp_stall_i) begin
            rsp_valid_o <= 1'b0;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign req_stall_o = (state_q != SIdle);

`ifndef SYNTHESIS
  // result only after the write-back step
  a_rsp_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q) == SWrite) else $error("early result");
  // a held result stays valid and its occupancy does not change while stalled
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(occupancy_o))
    else $error("result dropped");
  // eviction only on an insert
  a_evict_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && evicted_o |-> status_o == eptab_pkg::StInserted)
    else $error("bad eviction");
  // occupancy never exceeds depth
  a_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> 32'(occupancy_o) <= eptab_pkg::TableDepth) else $error("occupancy");
`endif

endmodule
